// ===== hw/rtl/bhp_pkg.sv =====
// Shared types, constants and interface structs of the BMP header parser.
`timescale 1ns / 1ps

package bhp_pkg;

  localparam logic [31:0] HeaderBytes  = 32'd54;
  localparam logic [15:0] BmpSignature = 16'h4d42;
  localparam logic [31:0] InfoSize     = 32'd40;
  localparam logic [15:0] PlaneCount   = 16'd1;
  localparam logic [31:0] BiRgb        = 32'd0;

  // Positions of little-endian field ends, multiply steps, header end.
  localparam logic [31:0] PosSigEnd    = 32'd1;
  localparam logic [31:0] PosResEnd    = 32'd9;
  localparam logic [31:0] PosOffEnd    = 32'd13;
  localparam logic [31:0] PosInfoEnd   = 32'd17;
  localparam logic [31:0] PosWidthEnd  = 32'd21;
  localparam logic [31:0] PosHeightEnd = 32'd25;
  localparam logic [31:0] PosPlanesEnd = 32'd27;
  localparam logic [31:0] PosBitsEnd   = 32'd29;
  localparam logic [31:0] PosMulWh     = 32'd30;
  localparam logic [31:0] PosMulBits   = 32'd31;
  localparam logic [31:0] PosCompEnd   = 32'd33;
  localparam logic [31:0] PosSizeEnd   = 32'd37;
  localparam logic [31:0] PosHdrLast   = 32'd53;

  localparam int unsigned OutDepthDefault = 4;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EOF       = 3'd1,
    ST_SIGNATURE = 3'd2,
    ST_RESERVED  = 3'd3,
    ST_INFO_SIZE = 3'd4,
    ST_PLANES    = 3'd5,
    ST_OFFSET    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    POS_HOLD = 2'd0,
    POS_INC  = 2'd1,
    POS_ONE  = 2'd2
  } pos_op_e;

  // Controller to datapath.
  typedef struct packed {
    logic    clear;
    logic    hdr_step;
    pos_op_e pos_op;
    logic    push_a;
    kind_e   kind_a;
    status_e status_a;
    logic    last_a;
    logic    push_b;
  } bhp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    status_e fail;
    logic    hdr_last;
    logic    gap_hit;
    logic    pay_last;
    logic    first_last;
    logic    size_zero;
    logic    offset_bad;
  } bhp_stat_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] bits;
    logic [31:0] comp;
    logic [31:0] size;
    status_e     status;
    logic        last;
  } bhp_result_t;

endpackage

// ===== hw/rtl/bhp_ctrl.sv =====
// Phase state machine: decides which results each accepted byte produces.
`timescale 1ns / 1ps

module bhp_ctrl import bhp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  logic      eof_i,
  input  bhp_stat_t stat_i,
  output bhp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_GAP     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_e;

  phase_e   phase_q, phase_d;
  bhp_cmd_t cmd;
  logic     stop;

  always_comb begin
    cmd          = '0;
    cmd.pos_op   = POS_HOLD;
    cmd.kind_a   = KIND_STATUS;
    cmd.status_a = ST_OK;
    phase_d      = phase_q;
    stop         = stat_i.offset_bad | stat_i.size_zero;
    if (fire_i) begin
      case (phase_q)
        PH_HEADER: begin
          cmd.hdr_step = 1'b1;
          cmd.pos_op   = POS_INC;
          if (stat_i.fail != ST_OK) begin
            cmd.push_a   = 1'b1;
            cmd.kind_a   = KIND_STATUS;
            cmd.status_a = stat_i.fail;
            cmd.last_a   = 1'b1;
            if (eof_i) cmd.clear = 1'b1;
            else       phase_d   = PH_DONE;
          end else if (stat_i.hdr_last) begin
            cmd.push_a   = 1'b1;
            cmd.kind_a   = KIND_HEADER;
            cmd.status_a = stat_i.offset_bad ? ST_OFFSET : ST_OK;
            cmd.last_a   = stop;
            if (stop) begin
              if (eof_i) cmd.clear = 1'b1;
              else       phase_d   = PH_DONE;
            end else if (eof_i) begin
              cmd.push_b = 1'b1;
              cmd.clear  = 1'b1;
            end else begin
              phase_d = PH_GAP;
            end
          end else if (eof_i) begin
            cmd.push_a   = 1'b1;
            cmd.kind_a   = KIND_STATUS;
            cmd.status_a = ST_EOF;
            cmd.last_a   = 1'b1;
            cmd.clear    = 1'b1;
          end
        end
        PH_GAP: begin
          if (stat_i.gap_hit) begin
            // This byte is payload byte zero.
            cmd.push_a = 1'b1;
            cmd.kind_a = KIND_PIXEL;
            cmd.last_a = stat_i.first_last;
            cmd.pos_op = POS_ONE;
            if (stat_i.first_last) begin
              if (eof_i) cmd.clear = 1'b1;
              else       phase_d   = PH_DONE;
            end else if (eof_i) begin
              cmd.push_b = 1'b1;
              cmd.clear  = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            cmd.pos_op = POS_INC;
            if (eof_i) begin
              cmd.push_a   = 1'b1;
              cmd.kind_a   = KIND_STATUS;
              cmd.status_a = ST_EOF;
              cmd.last_a   = 1'b1;
              cmd.clear    = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          cmd.push_a = 1'b1;
          cmd.kind_a = KIND_PIXEL;
          cmd.last_a = stat_i.pay_last;
          cmd.pos_op = POS_INC;
          if (stat_i.pay_last) begin
            if (eof_i) cmd.clear = 1'b1;
            else       phase_d   = PH_DONE;
          end else if (eof_i) begin
            cmd.push_b = 1'b1;
            cmd.clear  = 1'b1;
          end
        end
        PH_DONE: begin
          if (eof_i) cmd.clear = 1'b1;
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
      if (cmd.clear) phase_d = PH_HEADER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign cmd_o = cmd;

endmodule

// ===== hw/rtl/bhp_dp.sv =====
// Datapath: byte counter, field shifter, header registers, size multiplier.
`timescale 1ns / 1ps

module bhp_dp import bhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bhp_cmd_t    cmd_i,
  input  logic [7:0]  data_byte_i,
  output bhp_stat_t   stat_o,
  output bhp_result_t res_a_o,
  output bhp_result_t res_b_o
);

  logic [31:0] pos_q, pos_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] comp_q, comp_d;
  logic [31:0] size_q, size_d;

  // Two-step size product, each step registered, wrapping at 32 bits.
  logic [31:0] wh_q;
  logic [31:0] prod_q;
  logic [31:0] wh_full;
  logic [31:0] prod_full;

  logic [31:0] shift_nxt;
  logic [31:0] size_calc;
  status_e     fail;

  assign shift_nxt = {data_byte_i, shift_q[31:8]};
  assign wh_full   = width_q * height_q;
  assign prod_full = wh_q * {16'b0, bits_q};
  assign size_calc = (shift_nxt == 32'b0 && comp_q == BiRgb) ?
                     {3'b0, prod_q[31:3]} : shift_nxt;

  always_comb begin
    fail = ST_OK;
    if (pos_q == PosSigEnd && shift_nxt[31:16] != BmpSignature) fail = ST_SIGNATURE;
    if (pos_q == PosResEnd && shift_nxt != 32'b0)                fail = ST_RESERVED;
    if (pos_q == PosInfoEnd && shift_nxt != InfoSize)            fail = ST_INFO_SIZE;
    if (pos_q == PosPlanesEnd && shift_nxt[31:16] != PlaneCount) fail = ST_PLANES;
  end

  always_comb begin
    pos_d    = pos_q;
    shift_d  = shift_q;
    offset_d = offset_q;
    width_d  = width_q;
    height_d = height_q;
    bits_d   = bits_q;
    comp_d   = comp_q;
    size_d   = size_q;
    if (cmd_i.clear) begin
      pos_d    = '0;
      shift_d  = '0;
      offset_d = '0;
      width_d  = '0;
      height_d = '0;
      bits_d   = '0;
      comp_d   = '0;
      size_d   = '0;
    end else begin
      if (cmd_i.hdr_step) begin
        shift_d = shift_nxt;
        if (pos_q == PosOffEnd)    offset_d = shift_nxt;
        if (pos_q == PosWidthEnd)  width_d  = shift_nxt;
        if (pos_q == PosHeightEnd) height_d = shift_nxt;
        if (pos_q == PosBitsEnd)   bits_d   = shift_nxt[31:16];
        if (pos_q == PosCompEnd)   comp_d   = shift_nxt;
        if (pos_q == PosSizeEnd)   size_d   = size_calc;
      end
      case (cmd_i.pos_op)
        POS_HOLD: pos_d = pos_q;
        POS_INC:  pos_d = pos_q + 32'd1;
        POS_ONE:  pos_d = 32'd1;
        default:  pos_d = pos_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      shift_q  <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      bits_q   <= '0;
      comp_q   <= '0;
      size_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      bits_q   <= bits_d;
      comp_q   <= comp_d;
      size_q   <= size_d;
    end
  end

  // Width, height and bpp are all settled by byte 29; size is used at byte 37.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_step && pos_q == PosMulWh)   wh_q   <= wh_full;
    if (cmd_i.hdr_step && pos_q == PosMulBits) prod_q <= prod_full;
  end

  always_comb begin
    stat_o.fail       = fail;
    stat_o.hdr_last   = (pos_q == PosHdrLast);
    stat_o.gap_hit    = (pos_q == offset_q);
    stat_o.pay_last   = ((pos_q + 32'd1) == size_q);
    stat_o.first_last = (size_q == 32'd1);
    stat_o.size_zero  = (size_q == 32'd0);
    stat_o.offset_bad = (offset_q < HeaderBytes);
  end

  always_comb begin
    res_a_o        = '0;
    res_a_o.kind   = cmd_i.kind_a;
    res_a_o.status = cmd_i.status_a;
    res_a_o.last   = cmd_i.last_a;
    if (cmd_i.kind_a == KIND_PIXEL) res_a_o.pixel = data_byte_i;
    if (cmd_i.kind_a == KIND_HEADER) begin
      res_a_o.width  = width_q;
      res_a_o.height = height_q;
      res_a_o.bits   = bits_q;
      res_a_o.comp   = comp_q;
      res_a_o.size   = size_q;
    end
  end

  always_comb begin
    res_b_o        = '0;
    res_b_o.kind   = KIND_STATUS;
    res_b_o.status = ST_EOF;
    res_b_o.last   = 1'b1;
  end

endmodule

// ===== hw/rtl/bhp_outq.sv =====
// Result queue between the parser and the output channel.
`timescale 1ns / 1ps

module bhp_outq import bhp_pkg::*; #(
  parameter int unsigned Depth = OutDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_a_i,
  input  bhp_result_t res_a_i,
  input  logic        push_b_i,
  input  bhp_result_t res_b_i,
  input  logic        pop_i,
  output bhp_result_t head_o,
  output logic        valid_o,
  output logic        room_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bhp_result_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d, wr_nxt1, wr_nxt2;
  logic [CntW-1:0]     cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) return '0;
    else                       return p + 1'b1;
  endfunction

  assign wr_nxt1 = ptr_next(wr_q);
  assign wr_nxt2 = ptr_next(wr_nxt1);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push_a_i) wr_d = push_b_i ? wr_nxt2 : wr_nxt1;
    if (pop_i)    rd_d = ptr_next(rd_q);
    cnt_d = cnt_q + CntW'(push_a_i) + CntW'(push_b_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) mem_q[wr_q]    <= res_a_i;
    if (push_b_i) mem_q[wr_nxt1] <= res_b_i;
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  // One byte can produce two results.
  assign room_o  = (cnt_q <= CntW'(Depth - 2));

endmodule

// ===== hw/rtl/bmp_header_parser_core.sv =====
// Top level of the BMP header parser: byte stream in, header and payload results out.
`timescale 1ns / 1ps
//
// Input channel: one file byte per transaction (data_byte_i, end_of_file_i),
// in_valid_i / in_stall_o. end_of_file_i marks the final byte of a file.
// Output channel: one result per transaction, out_valid_o / out_stall_i.
// kind_o says payload byte, header summary or status only; last_o marks the
// final result of a file. Header fields are zero on other kinds.
//
// Throughput: one byte per cycle while in_stall_o is low. Each byte is handled in the
// cycle it is accepted and its results (at most two) enter a small result queue of
// OutDepth entries, whose registered storage drives the outputs.
// in_stall_o rises while fewer than two queue slots are free, so a
// stalled receiver backs up into the input channel after a few bytes and
// nothing is lost. The image size product is formed by two registered
// multiplies on header bytes 30 and 31, well before it is needed at byte 37.
//
// Reset clears the parser to the start of a new file and empties the queue.
// After end of file all header state returns to that same point.

module bmp_header_parser_core import bhp_pkg::*; #(
  parameter int unsigned OutDepth = OutDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  pixel_byte_o,
  output logic [31:0] width_o,
  output logic [31:0] height_o,
  output logic [15:0] pixel_bits_o,
  output logic [31:0] compression_o,
  output logic [31:0] image_size_bytes_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  bhp_cmd_t    cmd;
  bhp_stat_t   stat;
  bhp_result_t res_a, res_b, head;
  logic        in_fire, out_fire, room;

  assign in_stall_o = !room;
  assign in_fire    = in_valid_i && room;
  assign out_fire   = out_valid_o && !out_stall_i;

  bhp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .eof_i  (end_of_file_i),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bhp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (data_byte_i),
    .stat_o      (stat),
    .res_a_o     (res_a),
    .res_b_o     (res_b)
  );

  bhp_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (cmd.push_a),
    .res_a_i  (res_a),
    .push_b_i (cmd.push_b),
    .res_b_i  (res_b),
    .pop_i    (out_fire),
    .head_o   (head),
    .valid_o  (out_valid_o),
    .room_o   (room)
  );

  assign kind_o             = head.kind;
  assign pixel_byte_o       = head.pixel;
  assign width_o            = head.width;
  assign height_o           = head.height;
  assign pixel_bits_o       = head.bits;
  assign compression_o      = head.comp;
  assign image_size_bytes_o = head.size;
  assign status_o           = head.status;
  assign last_o             = head.last;

endmodule
